// ===== hw/rtl/u8d_pkg.sv =====
// Package for the streaming UTF-8 decoder.
// Holds the widths, constants, the queue item type and the lead byte
// classification shared by the interfaces, the front and back parts and the checker.
package u8d_pkg;

	localparam int unsigned CP_W        = 21;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned USED_W      = 3;
	localparam int unsigned LEN_W       = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CP_W-1:0] REPL_RESET = CP_W'(32'h0000_FFFD);
	localparam logic [CP_W-1:0] SURR_LO    = CP_W'(32'h0000_D800);
	localparam logic [CP_W-1:0] SURR_HI    = CP_W'(32'h0000_DFFF);
	localparam logic [CP_W-1:0] ASCII_END  = CP_W'(32'h0000_0080);

	// Sequence length codes; a lead byte that cannot start a sequence maps to LEN_BAD.
	localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
	localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
	localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
	localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
	localparam logic [LEN_W-1:0] LEN_4   = 3'd4;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_stream;
		logic [LEN_W-1:0]  seq_len;
	} u8d_item_t;

	function automatic logic [LEN_W-1:0] seq_length(input logic [BYTE_W-1:0] lead);
		logic [LEN_W-1:0] len;
		if ((lead & 8'h80) == 8'h00) begin
			len = LEN_1;
		end else if ((lead & 8'hE0) == 8'hC0) begin
			len = LEN_2;
		end else if ((lead & 8'hF0) == 8'hE0) begin
			len = LEN_3;
		end else if ((lead & 8'hF8) == 8'hF0) begin
			len = LEN_4;
		end else begin
			len = LEN_BAD;
		end
		return len;
	endfunction

endpackage

// ===== hw/rtl/u8d_intf.sv =====
// Handshake channels of the UTF-8 decoder: byte input, decoded result
// and the configuration write channel. Depends on u8d_pkg for widths.
interface u8d_byte_if import u8d_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              end_of_stream;

	modport source (output valid, data_byte, end_of_stream, input ready);
	modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

interface u8d_result_if import u8d_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CP_W-1:0]   codepoint;
	logic [USED_W-1:0] bytes_consumed;
	logic              is_error;
	logic              last_of_run;

	modport source (output valid, codepoint, bytes_consumed, is_error, last_of_run,
		input ready);
	modport sink   (input valid, codepoint, bytes_consumed, is_error, last_of_run,
		output ready);
endinterface

interface u8d_cfg_if import u8d_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CP_W-1:0] replacement_codepoint;

	modport source (output valid, replacement_codepoint, input ready);
	modport sink   (input valid, replacement_codepoint, output ready);
endinterface

// ===== hw/rtl/u8d_front.sv =====
// Front part of the UTF-8 decoder: accepts stream bytes, classifies the
// lead byte pattern and queues the items. Depends on u8d_pkg and u8d_byte_if.
module u8d_front import u8d_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	u8d_byte_if.sink     stream,
	output logic         item_valid,
	output u8d_item_t    item,
	input  logic         item_ready
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	u8d_item_t          queue_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign stream.ready = (count_q != CNT_W'(DEPTH));
	assign push         = stream.valid && stream.ready;
	assign item_valid   = (count_q != '0);
	assign pop          = item_valid && item_ready;
	assign item         = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{data_byte:     stream.data_byte,
			                       end_of_stream: stream.end_of_stream,
			                       seq_len:       seq_length(stream.data_byte)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/u8d_back.sv =====
// Back part of the UTF-8 decoder: holds the byte window, assembles and
// checks one sequence per cycle while the result register is free, and drives the result register.
// Depends on u8d_pkg, u8d_result_if and u8d_cfg_if.
module u8d_back import u8d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	input  u8d_item_t    item,
	output logic         item_ready,
	u8d_cfg_if.sink      cfg,
	u8d_result_if.source results
);

	logic [BYTE_W-1:0] win_q [4];
	logic [LEN_W-1:0]  len_q [4];
	logic [2:0]        cnt_q;
	logic              eos_q;
	logic              active_q;
	logic [CP_W-1:0]   repl_q;

	logic              out_valid_q;
	logic [CP_W-1:0]   out_cp_q;
	logic [USED_W-1:0] out_used_q;
	logic              out_err_q;
	logic              out_last_q;

	logic [LEN_W-1:0]  need;
	logic              bad_lead;
	logic              short_seq;
	logic              cont_ok;
	logic              surr;
	logic              seq_ok;
	logic [CP_W-1:0]   cp;
	logic [2:0]        consumed;
	logic [2:0]        cnt_rem;
	logic              can_emit;
	logic              out_free;
	logic              emit;
	logic              more;
	logic              take;
	logic [2:0]        cnt_new;
	logic [LEN_W-1:0]  front_len;
	logic              pop_more;
	logic [BYTE_W-1:0] win_ext [8];
	logic [LEN_W-1:0]  len_ext [8];
	logic [BYTE_W-1:0] win_sh [4];
	logic [LEN_W-1:0]  len_sh [4];

	assign cfg.ready = 1'b1;

	always_comb begin
		need      = len_q[0];
		bad_lead  = (need == LEN_BAD);
		short_seq = (need > cnt_q);

		case (need)
			LEN_1:   cp = {14'd0, win_q[0][6:0]};
			LEN_2:   cp = {10'd0, win_q[0][4:0], win_q[1][5:0]};
			LEN_3:   cp = {5'd0, win_q[0][3:0], win_q[1][5:0], win_q[2][5:0]};
			LEN_4:   cp = {win_q[0][2:0], win_q[1][5:0], win_q[2][5:0], win_q[3][5:0]};
			default: cp = '0;
		endcase

		cont_ok = 1'b1;
		for (int i = 1; i < 4; i++) begin
			if (3'(i) < need && win_q[i][7:6] != 2'b10) begin
				cont_ok = 1'b0;
			end
		end

		surr     = (cp >= SURR_LO) && (cp <= SURR_HI);
		seq_ok   = !bad_lead && !short_seq && cont_ok && !surr;
		consumed = seq_ok ? need : 3'd1;
		cnt_rem  = cnt_q - consumed;

		// A truncated sequence waits for more bytes unless the stream ends here.
		can_emit = active_q && (bad_lead || !short_seq || eos_q);
		out_free = !out_valid_q || results.ready;
		emit     = can_emit && out_free;

		for (int i = 0; i < 4; i++) begin
			win_ext[i] = win_q[i];
			len_ext[i] = len_q[i];
		end
		for (int i = 4; i < 8; i++) begin
			win_ext[i] = '0;
			len_ext[i] = LEN_BAD;
		end
		for (int i = 0; i < 4; i++) begin
			win_sh[i] = win_ext[3'(i) + consumed];
			len_sh[i] = len_ext[3'(i) + consumed];
		end

		// Whether the window left after this result yields another one in this run.
		more = (cnt_rem != 3'd0) && ((len_ext[consumed] == LEN_BAD)
			|| (len_ext[consumed] <= cnt_rem) || eos_q);

		item_ready = !active_q;
		take       = item_valid && !active_q;
		cnt_new    = cnt_q + 3'd1;
		front_len  = (cnt_q == 3'd0) ? item.seq_len : len_q[0];
		pop_more   = (front_len == LEN_BAD) || (front_len <= cnt_new) || item.end_of_stream;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			for (int i = 0; i < 4; i++) begin
				win_q[i] <= win_sh[i];
				len_q[i] <= len_sh[i];
			end
		end else if (take) begin
			win_q[cnt_q[1:0]] <= item.data_byte;
			len_q[cnt_q[1:0]] <= item.seq_len;
		end
		if (emit) begin
			out_cp_q   <= seq_ok ? cp : repl_q;
			out_used_q <= consumed;
			out_err_q  <= !seq_ok;
			out_last_q <= !more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			eos_q       <= 1'b0;
			active_q    <= 1'b0;
			repl_q      <= REPL_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				repl_q <= cfg.replacement_codepoint;
			end
			if (emit) begin
				cnt_q    <= cnt_rem;
				active_q <= more;
			end else if (take) begin
				cnt_q    <= cnt_new;
				eos_q    <= item.end_of_stream;
				active_q <= pop_more;
			end else if (active_q && !can_emit) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid          = out_valid_q;
	assign results.codepoint      = out_cp_q;
	assign results.bytes_consumed = out_used_q;
	assign results.is_error       = out_err_q;
	assign results.last_of_run    = out_last_q;

endmodule

// ===== hw/rtl/utf8_stream_decoder_top.sv =====
// Streaming UTF-8 decoder. A byte is taken whenever the input queue has room,
// one per cycle. The decoder behind the queue takes one byte from the queue and
// then delivers one result per cycle while the result is taken, and takes no new
// byte before it is through with the results of the last one. A byte that only
// extends a pending sequence gives no result. The rate is set by the back
// decoder, which resolves one sequence per cycle while the result is taken.
// Depends on u8d_pkg, the channel interfaces, u8d_front and u8d_back.
module utf8_stream_decoder_top import u8d_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	u8d_byte_if.sink      stream,
	u8d_cfg_if.sink       cfg,
	u8d_result_if.source  results
);

	logic      item_valid;
	logic      item_ready;
	u8d_item_t item;

	u8d_front #(
		.DEPTH(QUEUE_DEPTH_P)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.stream     (stream),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready)
	);

	u8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_ready (item_ready),
		.cfg        (cfg),
		.results    (results)
	);

endmodule

// ===== hw/rtl/u8d_checker.sv =====
// Port-level checks of the UTF-8 decoder results, bound to the top level.
// Depends on u8d_pkg for widths and code point constants.
module u8d_checker import u8d_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              res_valid,
	input logic              res_ready,
	input logic [CP_W-1:0]   res_codepoint,
	input logic [USED_W-1:0] res_used,
	input logic              res_error,
	input logic              res_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_codepoint)
			&& $stable(res_used) && $stable(res_error) && $stable(res_last))
		else $error("result item changed while stalled");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_used >= 3'd1 && res_used <= 3'd4)
		else $error("bytes_consumed out of range");

	a_error_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_error |-> res_used == 3'd1)
		else $error("error item accounts for more than one byte");

	a_no_surrogate: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_error |-> res_codepoint < SURR_LO || res_codepoint > SURR_HI)
		else $error("surrogate delivered as a valid code point");

	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_error && res_used == 3'd1 |-> res_codepoint < ASCII_END)
		else $error("single byte item above the ASCII range");

endmodule

bind utf8_stream_decoder_top u8d_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (results.valid),
	.res_ready     (results.ready),
	.res_codepoint (results.codepoint),
	.res_used      (results.bytes_consumed),
	.res_error     (results.is_error),
	.res_last      (results.last_of_run)
);

// ===== verif/utf8_stream_decoder_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder_top: streams directed and random
// UTF-8 byte sequences in and checks every decoded result against a built-in predictor.
// Depends on u8d_pkg, the channel interfaces in u8d_intf.sv and the decoder RTL.
module utf8_stream_decoder_top_tb import u8d_pkg::*; ();

	localparam int CLK_PERIOD       = 10;
	localparam int RESET_CYCLES     = 4;
	localparam int CYCLE_LIMIT      = 200000;
	localparam int SETTLE_CYCLES    = 10;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int MAX_REPORTS      = 10;
	localparam int PHASE_BYTES      = 60;

	typedef struct {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_stream;
	} stream_byte_t;

	typedef struct {
		logic [CP_W-1:0]   codepoint;
		logic [USED_W-1:0] bytes_consumed;
		logic              is_error;
		logic              last_of_run;
	} decoded_cp_t;

	logic clk = 1'b0;
	logic arst_n;

	u8d_byte_if   stream_if ();
	u8d_cfg_if    cfg_if ();
	u8d_result_if result_if ();

	utf8_stream_decoder_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_if),
		.cfg     (cfg_if),
		.results (result_if)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	stream_byte_t byte_q [$];
	decoded_cp_t  expected_cp_q [$];

	// Predictor state: bytes of an unfinished sequence and the replacement code point.
	logic [BYTE_W-1:0] pend_bytes [3];
	int                pend_cnt;
	logic [CP_W-1:0]   repl_cp;

	int bytes_queued    = 0;
	int bytes_offered   = 0;
	int bytes_accepted  = 0;
	int results_checked = 0;
	int error_results   = 0;
	int mismatches      = 0;
	int cycles          = 0;
	int cfg_writes      = 0;
	int holds_requested = 0;
	int holds_done      = 0;
	int send_gap        = 0;
	int recv_gap        = 0;
	int long_hold_left  = 0;
	bit no_idle         = 1'b0;

	// Appends one byte to the decode window and resolves as many sequences as possible.
	task automatic decode_stream_byte(input logic [BYTE_W-1:0] data, input logic eos);
		logic [BYTE_W-1:0] win [4];
		logic [CP_W-1:0]   cp;
		logic              good;
		decoded_cp_t       res;
		int                cnt;
		int                pos;
		int                need;
		int                first;
		first = expected_cp_q.size();
		cnt = 0;
		pos = 0;
		for (int i = 0; i < pend_cnt; i++) begin
			win[cnt] = pend_bytes[i];
			cnt++;
		end
		win[cnt] = data;
		cnt++;
		while (pos < cnt) begin
			if (!win[pos][7]) begin
				need = 1;
			end else if (win[pos][7:5] == 3'b110) begin
				need = 2;
			end else if (win[pos][7:4] == 4'b1110) begin
				need = 3;
			end else if (win[pos][7:3] == 5'b11110) begin
				need = 4;
			end else begin
				need = 0;
			end
			good = 1'b1;
			cp = '0;
			if (need == 0) begin
				good = 1'b0;
			end else if (need > cnt - pos) begin
				// Without end of stream, an incomplete tail waits for more bytes.
				if (!eos) break;
				good = 1'b0;
			end else begin
				case (need)
					1: begin
						cp = CP_W'(win[pos]);
					end
					2: begin
						cp = CP_W'({win[pos][4:0], win[pos+1][5:0]});
					end
					3: begin
						cp = CP_W'({win[pos][3:0], win[pos+1][5:0], win[pos+2][5:0]});
					end
					default: begin
						cp = {win[pos][2:0], win[pos+1][5:0], win[pos+2][5:0], win[pos+3][5:0]};
					end
				endcase
				if (cp >= SURR_LO && cp <= SURR_HI) good = 1'b0;
				for (int i = 1; i < need; i++) begin
					if (win[pos+i][7:6] != 2'b10) good = 1'b0;
				end
			end
			res.last_of_run = 1'b0;
			if (good) begin
				res.codepoint      = cp;
				res.bytes_consumed = USED_W'(need);
				res.is_error       = 1'b0;
				pos += need;
			end else begin
				res.codepoint      = repl_cp;
				res.bytes_consumed = USED_W'(1);
				res.is_error       = 1'b1;
				pos += 1;
			end
			expected_cp_q.push_back(res);
		end
		pend_cnt = 0;
		while (pos < cnt && pend_cnt < 3) begin
			pend_bytes[pend_cnt] = win[pos];
			pend_cnt++;
			pos++;
		end
		if (expected_cp_q.size() > first) begin
			expected_cp_q[expected_cp_q.size()-1].last_of_run = 1'b1;
		end
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eos);
		stream_byte_t item;
		item.data_byte     = b;
		item.end_of_stream = eos;
		byte_q.push_back(item);
		bytes_queued++;
	endtask

	// Mostly well-formed sequences with random payload, some broken ones and some noise.
	task automatic queue_random_seq();
		logic [BYTE_W-1:0] seq [4];
		int                len;
		int                keep;
		int                kind;
		kind = $urandom_range(0, 9);
		if (kind < 2) begin
			len = $urandom_range(1, 3);
			for (int i = 0; i < len; i++) seq[i] = 8'($urandom_range(0, 255));
			keep = len;
		end else begin
			len = $urandom_range(1, 4);
			case (len)
				1: begin
					seq[0] = {1'b0, 7'($urandom)};
				end
				2: begin
					seq[0] = {3'b110, 5'($urandom)};
				end
				3: begin
					seq[0] = {4'b1110, 4'($urandom)};
					// Bias toward the lead byte that can form a surrogate.
					if ($urandom_range(0, 3) == 0) seq[0] = 8'hED;
				end
				default: begin
					seq[0] = {5'b11110, 3'($urandom)};
				end
			endcase
			for (int i = 1; i < len; i++) seq[i] = {2'b10, 6'($urandom)};
			keep = len;
			if (len > 1 && kind == 2) begin
				if ($urandom_range(0, 1) == 1) begin
					seq[$urandom_range(1, len - 1)] = 8'($urandom);
				end else begin
					keep = $urandom_range(1, len - 1);
				end
			end
		end
		for (int i = 0; i < keep; i++) push_byte(seq[i], ($urandom_range(0, 19) == 0));
	endtask

	task automatic wait_drained();
		while (byte_q.size() != 0 || bytes_offered != bytes_accepted
				|| expected_cp_q.size() != 0) begin
			@(posedge clk);
		end
		// Bytes that only extend a pending sequence give no result but may still be in flight.
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_replacement(input logic [CP_W-1:0] value);
		@(negedge clk);
		cfg_if.replacement_codepoint <= value;
		cfg_if.valid <= 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_random_phase(input int n_bytes);
		int target;
		target = bytes_queued + n_bytes;
		while (bytes_queued < target) queue_random_seq();
		wait_drained();
	endtask

	always @(negedge clk) begin : drive_bytes
		stream_byte_t item;
		// An item stays on the channel until the monitor has seen it accepted.
		if (arst_n && !(stream_if.valid && bytes_accepted != bytes_offered)) begin
			if (send_gap > 0) begin
				send_gap--;
				stream_if.valid <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(0, 5);
				stream_if.valid <= 1'b0;
			end else if (byte_q.size() > 0) begin
				item = byte_q.pop_front();
				stream_if.data_byte <= item.data_byte;
				stream_if.end_of_stream <= item.end_of_stream;
				stream_if.valid <= 1'b1;
				bytes_offered++;
			end else begin
				stream_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : drive_ready
		if (arst_n) begin
			if (holds_done != holds_requested) begin
				holds_done++;
				long_hold_left = LONG_HOLD_CYCLES;
			end
			if (long_hold_left > 0) begin
				long_hold_left--;
				result_if.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				result_if.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				recv_gap = $urandom_range(0, 5);
				result_if.ready <= 1'b0;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_results
		decoded_cp_t want;
		if (!arst_n) begin
			pend_cnt = 0;
			repl_cp = REPL_RESET;
		end else begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles, %0d results still outstanding.",
					cycles, expected_cp_q.size());
				$display("RESULT: ERROR");
				$finish;
			end else begin
				if (cfg_if.valid && cfg_if.ready) begin
					repl_cp = cfg_if.replacement_codepoint;
					cfg_writes++;
				end
				if (stream_if.valid && stream_if.ready) begin
					decode_stream_byte(stream_if.data_byte, stream_if.end_of_stream);
					bytes_accepted++;
				end
				if (result_if.valid && result_if.ready) begin
					if (expected_cp_q.size() == 0) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("Unexpected result: cp %h used %0d err %b last %b",
								result_if.codepoint, result_if.bytes_consumed,
								result_if.is_error, result_if.last_of_run);
						end
					end else begin
						want = expected_cp_q.pop_front();
						results_checked++;
						if (want.is_error) error_results++;
						if (result_if.codepoint !== want.codepoint
								|| result_if.bytes_consumed !== want.bytes_consumed
								|| result_if.is_error !== want.is_error
								|| result_if.last_of_run !== want.last_of_run) begin
							mismatches++;
							if (mismatches <= MAX_REPORTS) begin
								$display("Mismatch on result %0d: expected cp %h used %0d err %b last %b,",
									results_checked, want.codepoint, want.bytes_consumed,
									want.is_error, want.last_of_run);
								$display("  got cp %h used %0d err %b last %b",
									result_if.codepoint, result_if.bytes_consumed,
									result_if.is_error, result_if.last_of_run);
							end
						end
					end
				end
			end
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.data_byte = '0;
		stream_if.end_of_stream = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.replacement_codepoint = '0;
		result_if.ready = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed bytes run with the replacement code point left at its reset value.
		push_byte(8'h00, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'hC2, 1'b0);
		push_byte(8'hA9, 1'b0);
		push_byte(8'hC0, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hE2, 1'b0);
		push_byte(8'h82, 1'b0);
		push_byte(8'hAC, 1'b0);
		// Encoded surrogate: the lead is rejected and both tail bytes are stray.
		push_byte(8'hED, 1'b0);
		push_byte(8'hA0, 1'b0);
		push_byte(8'h80, 1'b0);
		// Largest value reachable through an accepted F7 lead.
		push_byte(8'hF7, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hFF, 1'b0);
		// A three-byte lead followed by plain ASCII instead of continuations.
		push_byte(8'hE2, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'h42, 1'b0);
		// A four-byte sequence cut short by the end of the stream.
		push_byte(8'hF0, 1'b0);
		push_byte(8'h9F, 1'b1);
		wait_drained();

		write_replacement('0);
		// The receiver stalls for a long stretch while bytes keep coming.
		holds_requested++;
		run_random_phase(PHASE_BYTES);

		write_replacement('1);
		run_random_phase(PHASE_BYTES);

		write_replacement(CP_W'($urandom));
		run_random_phase(PHASE_BYTES);

		write_replacement(CP_W'($urandom));
		no_idle = 1'b1;
		run_random_phase(PHASE_BYTES);

		if (expected_cp_q.size() != 0) begin
			$display("%0d expected results never arrived.", expected_cp_q.size());
			mismatches += expected_cp_q.size();
		end
		$display("Decoded %0d stream bytes into %0d checked results, %0d of them errors.",
			bytes_accepted, results_checked, error_results);
		$display("Replacement register written %0d times, %0d failures.", cfg_writes, mismatches);
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== utf8_stream_decoder_top.f =====
hw/rtl/u8d_pkg.sv
hw/rtl/u8d_intf.sv
hw/rtl/u8d_front.sv
hw/rtl/u8d_back.sv
hw/rtl/utf8_stream_decoder_top.sv
hw/rtl/u8d_checker.sv
verif/utf8_stream_decoder_top_tb.sv
